[src/assert_macros.svh]
// assertion macros shared by the rtl files of the quaternion rotate block
// expects clk and rst to be visible in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check, also checked during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/qrv_pkg.sv]
// shared types and round/saturate helper for the quaternion rotate block
// no dependencies
package qrv_pkg;

  // widest component the block supports and the matching sum width
  localparam int MAX_W = 32;
  localparam int SUM_W = 72;

  typedef logic signed [MAX_W-1:0] comp_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // round half up after dropping frac bits, then clamp to a signed width-bit range
  function automatic comp_t rnd_sat(input sum_t sum, input int frac, input int width);
    sum_t half;
    sum_t t;
    sum_t hi;
    sum_t lo;
    half = sum_t'(1) <<< (frac - 1);
    t    = (sum + half) >>> frac;
    hi   = (sum_t'(1) <<< (width - 1)) - sum_t'(1);
    lo   = -(sum_t'(1) <<< (width - 1));
    if (t > hi) begin
      rnd_sat = comp_t'(hi);
    end else if (t < lo) begin
      rnd_sat = comp_t'(lo);
    end else begin
      rnd_sat = comp_t'(t);
    end
  endfunction

endpackage

[src/qrv_quat_if.sv]
// request channel: quaternion and vector with valid/ready
// no dependencies
interface qrv_quat_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] vec_x;
  logic signed [W-1:0] vec_y;
  logic signed [W-1:0] vec_z;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                output ready);
endinterface

[src/qrv_rot_if.sv]
// result channel: rotated vector and the nine matrix entries with valid/ready
// no dependencies
interface qrv_rot_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] rot_x;
  logic signed [W-1:0] rot_y;
  logic signed [W-1:0] rot_z;
  logic signed [W-1:0] m00;
  logic signed [W-1:0] m01;
  logic signed [W-1:0] m02;
  logic signed [W-1:0] m10;
  logic signed [W-1:0] m11;
  logic signed [W-1:0] m12;
  logic signed [W-1:0] m20;
  logic signed [W-1:0] m21;
  logic signed [W-1:0] m22;

  modport source (output valid, rot_x, rot_y, rot_z,
                  m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, rot_x, rot_y, rot_z,
                m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

[src/qrv_matrix.sv]
// stages 1-2: quaternion products, then rounded and saturated matrix entries
// depends on qrv_pkg, qrv_quat_if, assert_macros.svh
`include "assert_macros.svh"

module qrv_matrix #(
  parameter int W = 16,
  parameter int F = 14
) (
  input  logic                clk,
  input  logic                rst,
  qrv_quat_if.sink            item,
  output logic                mat_valid,
  input  logic                mat_ready,
  output logic signed [W-1:0] mat [9],
  output logic signed [W-1:0] vec [3]
);

  localparam int PW = 2 * W;

  // stage 1 registers
  logic                 v1;
  logic signed [PW-1:0] pww, pxx, pyy, pzz, pxy, pzw, pxz, pyw, pyz, pxw;
  logic signed [W-1:0]  vec1 [3];
  // stage 2 registers
  logic                 v2;

  logic en1, en2;
  qrv_pkg::sum_t s [9];

  assign en2        = !v2 || mat_ready;
  assign en1        = !v1 || en2;
  assign item.ready = en1;
  assign mat_valid  = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= item.valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pww     <= item.quat_w * item.quat_w;
      pxx     <= item.quat_x * item.quat_x;
      pyy     <= item.quat_y * item.quat_y;
      pzz     <= item.quat_z * item.quat_z;
      pxy     <= item.quat_x * item.quat_y;
      pzw     <= item.quat_z * item.quat_w;
      pxz     <= item.quat_x * item.quat_z;
      pyw     <= item.quat_y * item.quat_w;
      pyz     <= item.quat_y * item.quat_z;
      pxw     <= item.quat_x * item.quat_w;
      vec1[0] <= item.vec_x;
      vec1[1] <= item.vec_y;
      vec1[2] <= item.vec_z;
    end
  end

  // exact sums with 2F fraction bits
  always_comb begin
    s[0] = qrv_pkg::sum_t'(pww) + qrv_pkg::sum_t'(pxx)
         - qrv_pkg::sum_t'(pyy) - qrv_pkg::sum_t'(pzz);
    s[1] = (qrv_pkg::sum_t'(pxy) - qrv_pkg::sum_t'(pzw)) <<< 1;
    s[2] = (qrv_pkg::sum_t'(pxz) + qrv_pkg::sum_t'(pyw)) <<< 1;
    s[3] = (qrv_pkg::sum_t'(pxy) + qrv_pkg::sum_t'(pzw)) <<< 1;
    s[4] = qrv_pkg::sum_t'(pww) + qrv_pkg::sum_t'(pyy)
         - qrv_pkg::sum_t'(pzz) - qrv_pkg::sum_t'(pxx);
    s[5] = (qrv_pkg::sum_t'(pyz) - qrv_pkg::sum_t'(pxw)) <<< 1;
    s[6] = (qrv_pkg::sum_t'(pxz) - qrv_pkg::sum_t'(pyw)) <<< 1;
    s[7] = (qrv_pkg::sum_t'(pyz) + qrv_pkg::sum_t'(pxw)) <<< 1;
    s[8] = qrv_pkg::sum_t'(pww) + qrv_pkg::sum_t'(pzz)
         - qrv_pkg::sum_t'(pxx) - qrv_pkg::sum_t'(pyy);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 9; i++) begin
        mat[i] <= W'(qrv_pkg::rnd_sat(s[i], F, W));
      end
      for (int i = 0; i < 3; i++) begin
        vec[i] <= vec1[i];
      end
    end
  end

  // a refused request means both stages hold an item
  `ASSERT_CLK(a_mat_full_stall, !item.ready |-> (v1 && v2), "matrix stall with a bubble")
  // a blocked stage 1 item is kept
  `ASSERT_CLK(a_mat_s1_hold, (v1 && !en2) |=> v1, "matrix stage 1 item lost")

endmodule

[src/qrv_rotate.sv]
// stages 3-4: matrix times vector products, then rounded and saturated rotation
// depends on qrv_pkg, qrv_rot_if, assert_macros.svh
`include "assert_macros.svh"

module qrv_rotate #(
  parameter int W = 16,
  parameter int F = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                mat_valid,
  output logic                mat_ready,
  input  logic signed [W-1:0] mat [9],
  input  logic signed [W-1:0] vec [3],
  qrv_rot_if.source           result
);

  localparam int PW = 2 * W;

  logic                 v3, v4;
  logic                 en3, en4;
  logic signed [PW-1:0] prod [9];
  logic signed [W-1:0]  mat3 [9];
  logic signed [W-1:0]  mat4 [9];
  logic signed [W-1:0]  rot4 [3];
  qrv_pkg::sum_t        s [3];

  assign en4          = !v4 || result.ready;
  assign en3          = !v3 || en4;
  assign mat_ready    = en3;
  assign result.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en3) v3 <= mat_valid;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 9; i++) begin
        prod[i] <= mat[i] * vec[i % 3];
        mat3[i] <= mat[i];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s[r] = qrv_pkg::sum_t'(prod[3*r]) + qrv_pkg::sum_t'(prod[3*r+1])
           + qrv_pkg::sum_t'(prod[3*r+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int r = 0; r < 3; r++) begin
        rot4[r] <= W'(qrv_pkg::rnd_sat(s[r], F, W));
      end
      for (int i = 0; i < 9; i++) begin
        mat4[i] <= mat3[i];
      end
    end
  end

  assign result.rot_x = rot4[0];
  assign result.rot_y = rot4[1];
  assign result.rot_z = rot4[2];
  assign result.m00   = mat4[0];
  assign result.m01   = mat4[1];
  assign result.m02   = mat4[2];
  assign result.m10   = mat4[3];
  assign result.m11   = mat4[4];
  assign result.m12   = mat4[5];
  assign result.m20   = mat4[6];
  assign result.m21   = mat4[7];
  assign result.m22   = mat4[8];

  // upstream is held off only when both stages are full
  `ASSERT_CLK(a_rot_full_stall, !mat_ready |-> (v3 && v4), "rotate stall with a bubble")
  // a stage 3 item blocked by the output register is kept
  `ASSERT_CLK(a_rot_s3_hold, (v3 && !en4) |=> v3, "rotate stage 3 item lost")

endmodule

[src/quaternion_rotate_vector_core.sv]
// quaternion to rotation matrix and vector rotation, four register stages
// path: an accepted request moves through the stage 1, 2, 3 and 4 registers; result valid is the stage 4 valid bit
// throughput: one request per cycle; ready runs back through all four stages in one cycle,
// so a held result stalls the input only once every stage holds a request
// reset (rst, synchronous) clears the stage valid bits only; payload is not reset
// depends on qrv_pkg, qrv_quat_if, qrv_rot_if, qrv_matrix, qrv_rotate, assert_macros.svh
`include "assert_macros.svh"

module quaternion_rotate_vector_core #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic      clk,
  input  logic      rst,
  qrv_quat_if.sink  item,
  qrv_rot_if.source result
);

  // handoff between the matrix half and the rotation half
  logic                              mat_valid;
  logic                              mat_ready;
  // matrix entries in row order, already rounded and saturated
  logic signed [COMPONENT_WIDTH-1:0] mat [9];
  // vector delayed to line up with the matrix
  logic signed [COMPONENT_WIDTH-1:0] vec [3];

  // stage 1: ten quaternion products; stage 2: sums, rounding, clamping
  qrv_matrix #(
    .W (COMPONENT_WIDTH),
    .F (FRACTION_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .mat       (mat),
    .vec       (vec)
  );

  // stage 3: nine matrix-vector products; stage 4: row sums into the output register
  qrv_rotate #(
    .W (COMPONENT_WIDTH),
    .F (FRACTION_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .mat       (mat),
    .vec       (vec),
    .result    (result)
  );

  // no result may appear in the cycle after reset
  `ASSERT_ALWAYS(a_top_rst_clear, rst |=> !result.valid, "result valid after reset")

endmodule
